[src/spd_pkg.sv]
// Shared types and constants for the smoothed pinch detector.
// No dependencies; the detector and the checker refer to this package by scoped names.
package spd_pkg;

   // Sequencer states of the detector
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS,
      ST_MUL,
      ST_SUM,
      ST_SQRT,
      ST_SMOOTH,
      ST_DECIDE,
      ST_DIV,
      ST_FINISH
   } spd_state_type;

   // Register indexes (address bit 2 of the CSR port)
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_START     = 1'b1;

   localparam int CFG_W = 16;
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd1245;
   localparam logic [CFG_W-1:0] START_RESET     = 16'd3604;

   // Q1.15 unity and the number of quotient bits of the factor divide
   localparam logic [15:0] FACTOR_ONE = 16'h8000;
   localparam int DIV_STEPS = 15;

   // The squared distance is held to this many bits (saturating above)
   localparam int SUM_CAP = 64;

endpackage

[src/spd_req_if.sv]
// Input channel of the pinch detector: valid/ready plus two tip positions.
// Depends on nothing; width follows POS_BITS.
interface spd_req_if #(parameter int POS_BITS = 20) ();
   logic                       valid;
   logic                       ready;
   logic                       thumb_valid;
   logic                       index_valid;
   logic signed [POS_BITS-1:0] thumb_x;
   logic signed [POS_BITS-1:0] thumb_y;
   logic signed [POS_BITS-1:0] thumb_z;
   logic signed [POS_BITS-1:0] index_x;
   logic signed [POS_BITS-1:0] index_y;
   logic signed [POS_BITS-1:0] index_z;

   modport source (output valid, thumb_valid, index_valid, thumb_x, thumb_y, thumb_z,
                   index_x, index_y, index_z, input ready);
   modport sink   (input valid, thumb_valid, index_valid, thumb_x, thumb_y, thumb_z,
                   index_x, index_y, index_z, output ready);
endinterface

[src/spd_rsp_if.sv]
// Result channel of the pinch detector: valid/ready, pinching flag, Q1.15 factor.
// Depends on nothing.
interface spd_rsp_if ();
   logic        valid;
   logic        ready;
   logic        pinching;
   logic [15:0] pinch_factor;

   modport source (output valid, pinching, pinch_factor, input ready);
   modport sink   (input valid, pinching, pinch_factor, output ready);
endinterface

[src/smoothed_pinch_detector.sv]
// Smoothed pinch detector (square root width capped above POS_BITS=31). An item with
// either tip invalid goes straight to finish with a fixed answer; otherwise it runs the
// magnitude, squaring, root, smoothing and decision steps, plus a divide if needed.
// One item at a time: the next transfer is taken the cycle after the result is handed to
// the output register. Time is set by the bit-serial squarers, root and divider.
// Synchronous active-high reset: idle, no result, smoothed distance 0, CSRs to defaults.
module smoothed_pinch_detector #(
   parameter int POS_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   spd_req_if.sink     req_chan,
   spd_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DW     = POS_BITS + 1;                 // difference / distance width
   localparam int EXW    = 2 * DW;                       // exact square and sum width
   localparam int SUM_W  = (EXW > spd_pkg::SUM_CAP) ? spd_pkg::SUM_CAP : EXW;
   localparam int SQ_IT  = SUM_W / 2;                    // root bits, one per cycle
   localparam int REM_W  = SQ_IT + 2;
   localparam int MAXIT  = (DW > spd_pkg::DIV_STEPS) ? DW : spd_pkg::DIV_STEPS;
   localparam int CNT_W  = $clog2(MAXIT + 1);
   localparam int CW     = (DW > spd_pkg::CFG_W) ? DW : spd_pkg::CFG_W;
   localparam int QW     = spd_pkg::DIV_STEPS;

   spd_pkg::spd_state_type state_ff, state_in;

   logic [spd_pkg::CFG_W-1:0] threshold_ff, start_ff;
   logic                      csr_write;

   logic [DW-1:0]    diff_ff [3];
   logic [DW-1:0]    diff_in [3];
   logic [EXW-1:0]   mcand_ff [3];
   logic [EXW-1:0]   mcand_in [3];
   logic [DW-1:0]    mplier_ff [3];
   logic [DW-1:0]    mplier_in [3];
   logic [EXW-1:0]   acc_ff [3];
   logic [EXW-1:0]   acc_in [3];
   logic [DW-1:0]    mag [3];

   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [EXW-1:0]   sum_exact;
   logic [SUM_W-1:0] sum_sat;
   logic [SUM_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SQ_IT-1:0] root_ff, root_in;
   logic [REM_W-1:0] trial_rem, trial;

   logic [DW-1:0]    smooth_ff, smooth_in;
   logic [DW:0]      smooth_sum;

   logic [CW-1:0]    s_ext, t_ext, st_ext;
   logic             below_thr, factor_zero, at_thr;

   logic [spd_pkg::CFG_W:0]   drem_ff, drem_in, drem_shift, den;
   logic [QW-1:0]             quo_ff, quo_in;

   logic             res_pinch_ff, res_pinch_in;
   logic [15:0]      res_factor_ff, res_factor_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pinch_ff, rsp_pinch_in;
   logic [15:0]      rsp_factor_ff, rsp_factor_in;
   logic             out_free, req_take;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         spd_pkg::REG_THRESHOLD: csr_prdata = 32'(threshold_ff);
         spd_pkg::REG_START:     csr_prdata = 32'(start_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= spd_pkg::THRESHOLD_RESET;
         start_ff     <= spd_pkg::START_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == spd_pkg::REG_THRESHOLD) threshold_ff <= csr_pwdata[15:0];
         else                                        start_ff     <= csr_pwdata[15:0];
      end
   end

   // ---------------------------------------------------------------- handshakes
   assign req_chan.ready         = (state_ff == spd_pkg::ST_IDLE);
   assign req_take               = req_chan.valid & req_chan.ready;
   assign out_free               = ~rsp_valid_ff | rsp_chan.ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pinching      = rsp_pinch_ff;
   assign rsp_chan.pinch_factor  = rsp_factor_ff;

   // ---------------------------------------------------------------- datapath helpers
   // magnitudes of the registered differences
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = diff_ff[k][DW-1] ? (~diff_ff[k] + DW'(1)) : diff_ff[k];
      end
   end

   // three-way sum of squares, clamped to SUM_W bits
   assign sum_exact = acc_ff[0] + acc_ff[1] + acc_ff[2];

   generate
      if (EXW > SUM_W) begin : g_sat
         assign sum_sat = (|sum_exact[EXW-1:SUM_W]) ? '1 : sum_exact[SUM_W-1:0];
      end else begin : g_nosat
         assign sum_sat = sum_exact[SUM_W-1:0];
      end
   endgenerate

   // one root bit per cycle: bring down two radicand bits, try (root<<2)|1
   assign trial_rem = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1:SUM_W-2]};
   assign trial     = {root_ff, 2'b01};

   // smoothing add
   assign smooth_sum = (DW+1)'(DW'(root_ff)) + (DW+1)'(smooth_ff);

   // threshold decisions on the registered smoothed distance
   assign s_ext       = CW'(smooth_ff);
   assign t_ext       = CW'(threshold_ff);
   assign st_ext      = CW'(start_ff);
   assign below_thr   = s_ext < t_ext;
   assign factor_zero = (st_ext <= t_ext) || (s_ext >= st_ext);
   assign at_thr      = s_ext == t_ext;

   // restoring divide, one quotient bit per cycle
   assign drem_shift = {drem_ff[spd_pkg::CFG_W-1:0], 1'b0};
   assign den        = (spd_pkg::CFG_W+1)'(start_ff) - (spd_pkg::CFG_W+1)'(threshold_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spd_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_chan.thumb_valid & req_chan.index_valid) state_in = spd_pkg::ST_ABS;
               else                                             state_in = spd_pkg::ST_FINISH;
            end
         end
         spd_pkg::ST_ABS:    state_in = spd_pkg::ST_MUL;
         spd_pkg::ST_MUL: begin
            if (cnt_ff == CNT_W'(DW - 1)) state_in = spd_pkg::ST_SUM;
         end
         spd_pkg::ST_SUM:    state_in = spd_pkg::ST_SQRT;
         spd_pkg::ST_SQRT: begin
            if (cnt_ff == CNT_W'(SQ_IT - 1)) state_in = spd_pkg::ST_SMOOTH;
         end
         spd_pkg::ST_SMOOTH: state_in = spd_pkg::ST_DECIDE;
         spd_pkg::ST_DECIDE: begin
            if (below_thr || factor_zero || at_thr) state_in = spd_pkg::ST_FINISH;
            else                                    state_in = spd_pkg::ST_DIV;
         end
         spd_pkg::ST_DIV: begin
            if (cnt_ff == CNT_W'(QW - 1)) state_in = spd_pkg::ST_FINISH;
         end
         spd_pkg::ST_FINISH: begin
            if (out_free) state_in = spd_pkg::ST_IDLE;
         end
         default:            state_in = spd_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath next values
   always_comb begin
      diff_in       = diff_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      smooth_in     = smooth_ff;
      drem_in       = drem_ff;
      quo_in        = quo_ff;
      res_pinch_in  = res_pinch_ff;
      res_factor_in = res_factor_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_pinch_in  = rsp_pinch_ff;
      rsp_factor_in = rsp_factor_ff;

      unique case (state_ff)
         spd_pkg::ST_IDLE: begin
            // sign-extended coordinate differences
            diff_in[0] = {req_chan.thumb_x[POS_BITS-1], req_chan.thumb_x}
                       - {req_chan.index_x[POS_BITS-1], req_chan.index_x};
            diff_in[1] = {req_chan.thumb_y[POS_BITS-1], req_chan.thumb_y}
                       - {req_chan.index_y[POS_BITS-1], req_chan.index_y};
            diff_in[2] = {req_chan.thumb_z[POS_BITS-1], req_chan.thumb_z}
                       - {req_chan.index_z[POS_BITS-1], req_chan.index_z};
            // invalid tip: fixed answer, state untouched
            res_pinch_in  = 1'b0;
            res_factor_in = spd_pkg::FACTOR_ONE;
         end
         spd_pkg::ST_ABS: begin
            for (int k = 0; k < 3; k++) begin
               mcand_in[k]  = EXW'(mag[k]);
               mplier_in[k] = mag[k];
               acc_in[k]    = '0;
            end
            cnt_in = '0;
         end
         spd_pkg::ST_MUL: begin
            // shift-and-add squaring, one multiplier bit per cycle
            for (int k = 0; k < 3; k++) begin
               if (mplier_ff[k][0]) acc_in[k] = acc_ff[k] + mcand_ff[k];
               mcand_in[k]  = {mcand_ff[k][EXW-2:0], 1'b0};
               mplier_in[k] = {1'b0, mplier_ff[k][DW-1:1]};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         spd_pkg::ST_SUM: begin
            rad_in  = sum_sat;
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         spd_pkg::ST_SQRT: begin
            if (trial_rem >= trial) begin
               rem_in  = trial_rem - trial;
               root_in = {root_ff[SQ_IT-2:0], 1'b1};
            end else begin
               rem_in  = trial_rem;
               root_in = {root_ff[SQ_IT-2:0], 1'b0};
            end
            rad_in = {rad_ff[SUM_W-3:0], 2'b00};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         spd_pkg::ST_SMOOTH: begin
            smooth_in = smooth_sum[DW:1];
         end
         spd_pkg::ST_DECIDE: begin
            cnt_in = '0;
            quo_in = '0;
            // on the divide path s is below the start, so it fits the register width
            drem_in = (spd_pkg::CFG_W+1)'(start_ff)
                    - (spd_pkg::CFG_W+1)'(s_ext[spd_pkg::CFG_W-1:0]);
            priority if (below_thr) begin
               res_pinch_in  = 1'b1;
               res_factor_in = spd_pkg::FACTOR_ONE;
            end else if (factor_zero) begin
               res_pinch_in  = 1'b0;
               res_factor_in = '0;
            end else if (at_thr) begin
               // exactly at the threshold the ramp is at full scale, beyond the quotient
               res_pinch_in  = 1'b0;
               res_factor_in = spd_pkg::FACTOR_ONE;
            end else begin
               res_pinch_in  = 1'b0;
            end
         end
         spd_pkg::ST_DIV: begin
            if (drem_shift >= den) begin
               drem_in = drem_shift - den;
               quo_in  = {quo_ff[QW-2:0], 1'b1};
            end else begin
               drem_in = drem_shift;
               quo_in  = {quo_ff[QW-2:0], 1'b0};
            end
            res_factor_in = {1'b0, quo_in};
            cnt_in        = cnt_ff + CNT_W'(1);
         end
         spd_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pinch_in  = res_pinch_ff;
               rsp_factor_in = res_factor_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         smooth_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         smooth_ff    <= smooth_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      drem_ff       <= drem_in;
      quo_ff        <= quo_in;
      res_pinch_ff  <= res_pinch_in;
      res_factor_ff <= res_factor_in;
      rsp_pinch_ff  <= rsp_pinch_in;
      rsp_factor_ff <= rsp_factor_in;
   end

endmodule

[src/spd_checker.sv]
// Port-level checks for the smoothed pinch detector, bound to the top level.
// Depends on spd_pkg and on the top level's port names.
module spd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_thumb_valid,
   input logic        req_index_valid,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_pinching,
   input logic [15:0] rsp_pinch_factor
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pinching)
                                  && $stable(rsp_pinch_factor))
      else $error("stalled result changed");

   // pinching always comes with a full factor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pinching |-> rsp_pinch_factor == spd_pkg::FACTOR_ONE)
      else $error("pinching without full factor");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // an invalid tip gives the fixed answer through the finish state when the output is free
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(req_thumb_valid && req_index_valid) && !rsp_valid
      |=> ##1 rsp_valid && !rsp_pinching && rsp_pinch_factor == spd_pkg::FACTOR_ONE)
      else $error("invalid tip result wrong or late");

endmodule

bind smoothed_pinch_detector spd_checker u_spd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_thumb_valid  (req_chan.thumb_valid),
   .req_index_valid  (req_chan.index_valid),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pinching     (rsp_chan.pinching),
   .rsp_pinch_factor (rsp_chan.pinch_factor)
);
